[src/i2c_register_access_master_core_defines.svh]
// ----------------------------------------------------------------------------
// I2C register access master - assertion macros
// Shared property shorthands for the port checker.
// ----------------------------------------------------------------------------
`ifndef I2C_REGISTER_ACCESS_MASTER_CORE_DEFINES_SVH
`define I2C_REGISTER_ACCESS_MASTER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define I2CRAM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define I2CRAM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/i2cram_pkg.sv]
// ----------------------------------------------------------------------------
// I2C register access master - package
// Beat types, command codes, phase encoding and sequencer state.
// ----------------------------------------------------------------------------
package i2cram_pkg;

  localparam logic [7:0] DEV_ADDR_RST = 8'h22;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_BURST = 2'd3
  } op_e;

  typedef enum logic [8:0] {
    PH_IDLE   = 9'b000000001,
    PH_START  = 9'b000000010,
    PH_ADDRW  = 9'b000000100,
    PH_REG    = 9'b000001000,
    PH_DATA   = 9'b000010000,
    PH_RSTART = 9'b000100000,
    PH_ADDRR  = 9'b001000000,
    PH_RECV   = 9'b010000000,
    PH_STOP   = 9'b100000000
  } phase_e;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] register_number;
    logic [7:0] write_data;
    logic [7:0] byte_count;
    logic       sda_in;
  } in_t;

  typedef struct packed {
    logic       scl_low;
    logic       sda_low;
    logic       busy_res;
    logic       byte_valid;
    logic [7:0] read_byte;
    logic       last_byte;
    logic       done_res;
    logic       address_nack;
  } out_t;

  typedef struct packed {
    phase_e     phase;
    logic [1:0] qcnt;
    logic [3:0] bcnt;
    logic [7:0] shift;
    logic [7:0] bytes_left;
    logic [1:0] hop;
    logic [7:0] hreg;
    logic [7:0] hdata;
    logic       nack;
    logic       scl;
    logic       sda;
  } st_t;

  // Sequencer state after reset: idle, both lines released, all else zero.
  localparam st_t ST_RST = '{phase: PH_IDLE, default: '0};

endpackage

[src/i2cram_step.sv]
// ----------------------------------------------------------------------------
// I2C register access master - sequencer step
// Next state and result for one beat, given the current sequencer state.
// ----------------------------------------------------------------------------
module i2cram_step import i2cram_pkg::*; (
  input  st_t        cur_i,
  input  in_t        item_i,
  input  logic [7:0] dev_addr_i,
  output st_t        nxt_o,
  output out_t       res_o
);

  op_e  op;
  logic q_end;
  logic bit_phase;
  logic is_addr;

  assign op        = op_e'(item_i.operation);
  assign q_end     = (cur_i.qcnt == 2'd3);
  assign bit_phase = (cur_i.bcnt < 4'd8);
  assign is_addr   = (cur_i.phase == PH_ADDRW) || (cur_i.phase == PH_ADDRR);

  always_comb begin
    nxt_o = cur_i;
    res_o = '0;
    if (cur_i.phase == PH_IDLE) begin
      nxt_o.scl = 1'b0;
      nxt_o.sda = 1'b0;
      if (op != OP_TICK) begin
        nxt_o.hop   = item_i.operation;
        nxt_o.hreg  = item_i.register_number;
        nxt_o.hdata = item_i.write_data;
        if (op == OP_BURST && item_i.byte_count != 8'd0) begin
          nxt_o.bytes_left = item_i.byte_count;
        end else begin
          nxt_o.bytes_left = 8'd1;
        end
        nxt_o.nack  = 1'b0;
        nxt_o.bcnt  = 4'd0;
        nxt_o.qcnt  = 2'd0;
        nxt_o.phase = PH_START;
      end
    end else if (op == OP_TICK) begin
      nxt_o.qcnt = cur_i.qcnt + 2'd1;
      case (cur_i.phase)
        PH_START: begin
          if (cur_i.qcnt >= 2'd2) nxt_o.sda = 1'b1;
          nxt_o.scl = 1'b0;
          if (q_end) begin
            nxt_o.phase = PH_ADDRW;
            nxt_o.shift = dev_addr_i;
            nxt_o.bcnt  = 4'd0;
          end
        end
        PH_RSTART: begin
          case (cur_i.qcnt)
            2'd0:    nxt_o.scl = 1'b1;
            2'd1:    nxt_o.sda = 1'b0;
            2'd2:    nxt_o.scl = 1'b0;
            default: nxt_o.sda = 1'b1;
          endcase
          if (q_end) begin
            nxt_o.phase = PH_ADDRR;
            nxt_o.shift = dev_addr_i | 8'h01;
            nxt_o.bcnt  = 4'd0;
          end
        end
        PH_ADDRW, PH_REG, PH_DATA, PH_ADDRR: begin
          if (cur_i.qcnt == 2'd0) nxt_o.scl = 1'b1;
          else if (cur_i.qcnt == 2'd2) nxt_o.scl = 1'b0;
          if (bit_phase) begin
            if (cur_i.qcnt == 2'd1) nxt_o.sda = ~cur_i.shift[7];
            if (q_end) begin
              nxt_o.shift = {cur_i.shift[6:0], 1'b0};
              nxt_o.bcnt  = cur_i.bcnt + 4'd1;
            end
          end else begin
            if (cur_i.qcnt == 2'd1) nxt_o.sda = 1'b0;
            if (q_end) begin
              if (is_addr) begin
                if (item_i.sda_in) begin
                  nxt_o.nack  = 1'b1;
                  nxt_o.phase = PH_STOP;
                end else if (cur_i.phase == PH_ADDRW) begin
                  nxt_o.phase = PH_REG;
                  nxt_o.shift = cur_i.hreg;
                  nxt_o.bcnt  = 4'd0;
                end else begin
                  nxt_o.phase = PH_RECV;
                  nxt_o.shift = 8'd0;
                  nxt_o.bcnt  = 4'd0;
                end
              end else if (cur_i.phase == PH_REG) begin
                if (op_e'(cur_i.hop) == OP_WRITE) begin
                  nxt_o.phase = PH_DATA;
                  nxt_o.shift = cur_i.hdata;
                  nxt_o.bcnt  = 4'd0;
                end else begin
                  nxt_o.phase = PH_RSTART;
                end
              end else begin
                nxt_o.phase = PH_STOP;
              end
            end
          end
        end
        PH_RECV: begin
          if (cur_i.qcnt == 2'd0) nxt_o.scl = 1'b1;
          else if (cur_i.qcnt == 2'd2) nxt_o.scl = 1'b0;
          if (bit_phase) begin
            if (cur_i.qcnt == 2'd1) nxt_o.sda = 1'b0;
            if (q_end) begin
              nxt_o.shift = {cur_i.shift[6:0], item_i.sda_in};
              nxt_o.bcnt  = cur_i.bcnt + 4'd1;
            end
          end else begin
            if (cur_i.qcnt == 2'd1) nxt_o.sda = (cur_i.bytes_left > 8'd1);
            if (q_end) begin
              res_o.byte_valid = 1'b1;
              res_o.read_byte  = cur_i.shift;
              res_o.last_byte  = (cur_i.bytes_left <= 8'd1);
              if (cur_i.bytes_left <= 8'd1) begin
                nxt_o.bytes_left = 8'd0;
                nxt_o.phase      = PH_STOP;
              end else begin
                nxt_o.bytes_left = cur_i.bytes_left - 8'd1;
                nxt_o.bcnt       = 4'd0;
                nxt_o.shift      = 8'd0;
              end
            end
          end
        end
        PH_STOP: begin
          case (cur_i.qcnt)
            2'd0: nxt_o.scl = 1'b1;
            2'd1: nxt_o.sda = 1'b1;
            2'd2: nxt_o.scl = 1'b0;
            default: begin
              nxt_o.sda          = 1'b0;
              res_o.done_res     = 1'b1;
              res_o.address_nack = cur_i.nack;
              nxt_o.phase        = PH_IDLE;
            end
          endcase
        end
        default: begin
          nxt_o.phase = PH_IDLE;
          nxt_o.qcnt  = 2'd0;
          nxt_o.scl   = 1'b0;
          nxt_o.sda   = 1'b0;
        end
      endcase
    end
    res_o.scl_low  = nxt_o.scl;
    res_o.sda_low  = nxt_o.sda;
    res_o.busy_res = (nxt_o.phase != PH_IDLE);
  end

endmodule

[src/i2c_register_access_master_core.sv]
// ----------------------------------------------------------------------------
// I2C register access master - top level
// Register write, register read and burst read transactions on an
// open-drain bus, advanced one quarter-bit per tick beat.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake              Beat
//  --------  ---------  ---------------------  ------------------------------
//  in        sink       in_valid_i/in_ready_o  in_t: tick with SDA or command
//  out       source     out_valid_o/out_ready_i out_t: drive levels, read byte
//  cfg       sink       cfg_we_i               device address byte, no wait
//
//  Every beat passes through the input register, then through the sequencer
//  step into the result register; the state loop closes through st_q.
//  A new beat is taken every cycle while the result is not stalled.
//  Reset releases both lines, idles the sequencer and loads address 0x22.
//  A stalled result holds the input register, which in turn drops ready.
//
module i2c_register_access_master_core import i2cram_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_t        in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_t       out_data_o,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i
);

  logic       in_vld_q, in_vld_d;
  in_t        in_q;
  logic       out_vld_q, out_vld_d;
  out_t       out_q;
  st_t        st_q, st_d;
  out_t       res;
  logic [7:0] dev_addr_q;
  logic       adv;
  logic       fire;
  logic       in_acc;

  // Advance when the result register is free or being emptied this cycle.
  assign adv        = !out_vld_q || out_ready_i;
  assign fire       = in_vld_q && adv;
  assign in_ready_o = !in_vld_q || adv;
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_acc) begin
      in_vld_d = 1'b1;
    end else if (fire) begin
      in_vld_d = 1'b0;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (fire) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  i2cram_step u_step (
    .cur_i      (st_q),
    .item_i     (in_q),
    .dev_addr_i (dev_addr_q),
    .nxt_o      (st_d),
    .res_o      (res)
  );

  // Control state and sequencer state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q       <= 1'b0;
      out_vld_q      <= 1'b0;
      dev_addr_q     <= DEV_ADDR_RST;
      st_q           <= ST_RST;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (cfg_we_i) begin
        dev_addr_q <= cfg_wdata_i;
      end
      if (fire) begin
        st_q <= st_d;
      end
    end
  end

  // Payload registers: hold while stalled.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_q <= in_data_i;
    end
    if (fire) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

[src/i2cram_checker.sv]
// ----------------------------------------------------------------------------
// I2C register access master - port checker
// Watches the result channel of the top level over time.
// ----------------------------------------------------------------------------
`include "i2c_register_access_master_core_defines.svh"

module i2cram_checker import i2cram_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid_o,
  input logic out_ready_i,
  input out_t out_data_o
);

  `I2CRAM_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o), "stalled result beat changed")

  `I2CRAM_ASSERT_IMPL(a_byte_clean, out_valid_o && !out_data_o.byte_valid, out_data_o.read_byte == 8'd0 && !out_data_o.last_byte, "byte fields set without a byte")

  `I2CRAM_ASSERT_IMPL(a_nack_done, out_valid_o && out_data_o.address_nack, out_data_o.done_res, "address nack outside stop")

  `I2CRAM_ASSERT_IMPL(a_done_idle, out_valid_o && out_data_o.done_res, !out_data_o.busy_res && !out_data_o.scl_low && !out_data_o.sda_low, "stop left bus driven or busy")

  `I2CRAM_ASSERT_IMPL(a_byte_busy, out_valid_o && out_data_o.byte_valid, out_data_o.busy_res && !out_data_o.done_res, "byte reported outside transaction")

endmodule

bind i2c_register_access_master_core i2cram_checker u_checker (.*);
